@@ hw/rtl/mrcs_pkg.sv @@
// ----------------------------------------------------------------------------
// mrcs_pkg
// Shared constants and types of the mixed radix calendar split block.
// ----------------------------------------------------------------------------
package mrcs_pkg;

  localparam int unsigned DefTimeWidth  = 48;
  localparam int unsigned DefRadixWidth = 16;
  localparam int unsigned NumRadices    = 5;
  localparam int unsigned FieldWidth    = 16;

  // Register indexes of the configuration port.
  typedef enum logic [2:0] {
    REG_SECS_PER_MINUTE = 3'd0,
    REG_MINS_PER_HOUR   = 3'd1,
    REG_HOURS_PER_DAY   = 3'd2,
    REG_DAYS_PER_MONTH  = 3'd3,
    REG_MONTHS_PER_YEAR = 3'd4
  } reg_idx_e;

endpackage

@@ hw/rtl/mrcs_div_stage.sv @@
// ----------------------------------------------------------------------------
// mrcs_div_stage
// One pipelined restoring divider stage: a chain of registered steps, each
// step resolving a few quotient bits, with sideband data carried alongside.
// ----------------------------------------------------------------------------
module mrcs_div_stage
  import mrcs_pkg::*;
#(
  parameter int unsigned TimeWidth  = DefTimeWidth,
  parameter int unsigned RadixWidth = DefRadixWidth,
  parameter int unsigned SideWidth  = 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  adv_i,
  input  logic                  valid_i,
  input  logic [TimeWidth-1:0]  dividend_i,
  input  logic [RadixWidth-1:0] divisor_i,
  input  logic [SideWidth-1:0]  side_i,
  output logic                  valid_o,
  output logic [TimeWidth-1:0]  quot_o,
  output logic [RadixWidth-1:0] rem_o,
  output logic [SideWidth-1:0]  side_o
);

  localparam int unsigned BitsPerStep = 8;
  localparam int unsigned NumSteps    = (TimeWidth + BitsPerStep - 1) / BitsPerStep;
  localparam int unsigned RemWidth    = RadixWidth + 1;

  logic                  vld_q  [NumSteps+1];
  logic [TimeWidth-1:0]  num_q  [NumSteps+1];
  logic [RadixWidth-1:0] rem_q  [NumSteps+1];
  logic [RadixWidth-1:0] div_q  [NumSteps+1];
  logic [SideWidth-1:0]  side_q [NumSteps+1];

  // Stage 0 is the input, not a register.
  assign vld_q[0]  = valid_i;
  assign num_q[0]  = dividend_i;
  assign rem_q[0]  = '0;
  assign div_q[0]  = divisor_i;
  assign side_q[0] = side_i;

  for (genvar s = 0; s < NumSteps; s++) begin : g_step
    // The last step resolves whatever quotient bits remain.
    localparam int StepBits = (s == NumSteps - 1) ?
      int'(TimeWidth - BitsPerStep * (NumSteps - 1)) : int'(BitsPerStep);

    logic [TimeWidth-1:0]  num_d;
    logic [RadixWidth-1:0] rem_d;

    always_comb begin
      logic [RemWidth-1:0] r;
      logic [TimeWidth-1:0] n;
      r = {1'b0, rem_q[s]};
      n = num_q[s];
      for (int b = 0; b < StepBits; b++) begin
        r = {r[RadixWidth-1:0], n[TimeWidth-1]};
        n = {n[TimeWidth-2:0], 1'b0};
        if (r >= {1'b0, div_q[s]}) begin
          r    = r - {1'b0, div_q[s]};
          n[0] = 1'b1;
        end
      end
      num_d = n;
      rem_d = r[RadixWidth-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (adv_i) begin
        vld_q[s+1] <= vld_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        num_q[s+1]  <= num_d;
        rem_q[s+1]  <= rem_d;
        div_q[s+1]  <= div_q[s];
        side_q[s+1] <= side_q[s];
      end
    end
  end

  assign valid_o = vld_q[NumSteps];
  assign quot_o  = num_q[NumSteps];
  assign rem_o   = rem_q[NumSteps];
  assign side_o  = side_q[NumSteps];

  a_hold_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv_i |=> $stable(valid_o))
    else $error("valid changed while held");

  a_hold_data : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!adv_i && valid_o) |=> ($stable(quot_o) && $stable(rem_o)))
    else $error("held result changed");

  a_rem_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (rem_o < div_q[NumSteps]))
    else $error("remainder not below divisor");

endmodule

@@ hw/rtl/mixed_radix_calendar_split.sv @@
// ----------------------------------------------------------------------------
// mixed_radix_calendar_split
// Splits an elapsed second count into calendar fields by five divisions.
// ----------------------------------------------------------------------------
// Usage: write the five radix registers over the APB port while the block is
// idle, then send one elapsed_seconds_i transaction per cycle on the input
// channel (valid/stall). Each transaction yields exactly one result
// transaction on the output channel, in order.
// The work runs through five pipelined dividers, one per radix. Each divider
// resolves up to eight quotient bits per register step, and the pipeline ends
// in one output register. Throughput is one transaction per cycle while the
// output is not stalled.
// The whole pipeline advances as one; when the receiver stalls a full output
// register, every stage holds and the input stall is raised, so nothing is
// lost or repeated. Reset clears all valid bits and the radix registers; with
// any radix zero the result carries date_valid_o low and all fields zero.
// The zero check samples the registers at the input and travels with the data.
// ----------------------------------------------------------------------------
module mixed_radix_calendar_split
  import mrcs_pkg::*;
#(
  parameter int unsigned TIME_WIDTH  = DefTimeWidth,
  parameter int unsigned RADIX_WIDTH = DefRadixWidth
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [4:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [TIME_WIDTH-1:0]  elapsed_seconds_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [FieldWidth-1:0]  second_of_minute_o,
  output logic [FieldWidth-1:0]  minute_of_hour_o,
  output logic [FieldWidth-1:0]  hour_of_day_o,
  output logic [FieldWidth-1:0]  day_in_month_o,
  output logic [FieldWidth-1:0]  month_in_year_o,
  output logic [TIME_WIDTH-1:0]  year_count_o,
  output logic                   date_valid_o
);

  localparam int unsigned SideW = 1 + 4 * RADIX_WIDTH;

  logic [RADIX_WIDTH-1:0] radix_q [NumRadices];
  logic [2:0]             reg_idx;
  logic                   wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRadices; i++) radix_q[i] <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_SECS_PER_MINUTE: radix_q[0] <= pwdata[RADIX_WIDTH-1:0];
        REG_MINS_PER_HOUR:   radix_q[1] <= pwdata[RADIX_WIDTH-1:0];
        REG_HOURS_PER_DAY:   radix_q[2] <= pwdata[RADIX_WIDTH-1:0];
        REG_DAYS_PER_MONTH:  radix_q[3] <= pwdata[RADIX_WIDTH-1:0];
        REG_MONTHS_PER_YEAR: radix_q[4] <= pwdata[RADIX_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_SECS_PER_MINUTE: prdata = 32'(radix_q[0]);
      REG_MINS_PER_HOUR:   prdata = 32'(radix_q[1]);
      REG_HOURS_PER_DAY:   prdata = 32'(radix_q[2]);
      REG_DAYS_PER_MONTH:  prdata = 32'(radix_q[3]);
      REG_MONTHS_PER_YEAR: prdata = 32'(radix_q[4]);
      default:             prdata = '0;
    endcase
  end

  // The pipeline advances unless a result waits in the output register.
  logic adv;
  logic out_vld_q;
  assign adv        = !(out_vld_q && out_stall_i);
  assign in_stall_o = !adv;

  // A zero radix is replaced by one so the dividers never see zero; the
  // flag then forces the result fields to zero.
  logic ok_in;
  logic [RADIX_WIDTH-1:0] rad_safe [NumRadices];
  always_comb begin
    ok_in = 1'b1;
    for (int i = 0; i < NumRadices; i++) begin
      ok_in       = ok_in && (radix_q[i] != '0);
      rad_safe[i] = (radix_q[i] == '0) ? RADIX_WIDTH'(1) : radix_q[i];
    end
  end

  logic                   vld   [NumRadices+1];
  logic [TIME_WIDTH-1:0]  quot  [NumRadices+1];
  logic [SideW-1:0]       side  [NumRadices+1];
  logic [RADIX_WIDTH-1:0] rem   [NumRadices];

  // Side word: ok flag, earlier remainders, and later radices share slots.
  // Radices are sampled at entry; the user must change registers only while idle, the block does not enforce it.
  assign vld[0]  = in_valid_i && adv;
  assign quot[0] = elapsed_seconds_i;
  assign side[0] = {ok_in, rad_safe[1], rad_safe[2], rad_safe[3], rad_safe[4]};

  for (genvar k = 0; k < NumRadices; k++) begin : g_div
    logic [RADIX_WIDTH-1:0] divisor;
    logic [SideW-1:0]       side_nx;
    if (k == 0) begin : g_first
      assign divisor = rad_safe[0];
      assign side_nx = side[0];
    end else begin : g_rest
      assign divisor = side[k][(4-k+1)*RADIX_WIDTH-1 -: RADIX_WIDTH];

      // Once divisor k is consumed its slot carries remainder k-1 onward.
      always_comb begin
        side_nx = side[k];
        side_nx[(4-k+1)*RADIX_WIDTH-1 -: RADIX_WIDTH] = rem[k-1];
      end
    end

    mrcs_div_stage #(
      .TimeWidth (TIME_WIDTH),
      .RadixWidth(RADIX_WIDTH),
      .SideWidth (SideW)
    ) u_div (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .adv_i     (adv),
      .valid_i   (vld[k]),
      .dividend_i(quot[k]),
      .divisor_i (divisor),
      .side_i    (side_nx),
      .valid_o   (vld[k+1]),
      .quot_o    (quot[k+1]),
      .rem_o     (rem[k]),
      .side_o    (side[k+1])
    );
  end

  logic ok_out;
  assign ok_out = side[NumRadices][SideW-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= vld[NumRadices];
    end
  end

  logic [FieldWidth-1:0] f_q [NumRadices];
  logic [TIME_WIDTH-1:0] year_q;
  logic                  ok_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ok_q   <= ok_out;
      year_q <= ok_out ? quot[NumRadices] : '0;
      for (int i = 0; i < NumRadices - 1; i++) begin
        f_q[i] <= ok_out ?
          FieldWidth'(side[NumRadices][(4-i)*RADIX_WIDTH-1 -: RADIX_WIDTH]) : '0;
      end
      f_q[NumRadices-1] <= ok_out ? FieldWidth'(rem[NumRadices-1]) : '0;
    end
  end

  assign out_valid_o        = out_vld_q;
  assign second_of_minute_o = f_q[0];
  assign minute_of_hour_o   = f_q[1];
  assign hour_of_day_o      = f_q[2];
  assign day_in_month_o     = f_q[3];
  assign month_in_year_o    = f_q[4];
  assign year_count_o       = year_q;
  assign date_valid_o       = ok_q;

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o && $stable(year_count_o))
    else $error("stalled result changed");

  a_in_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without output stall");

  a_invalid_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !date_valid_o) |-> (year_count_o == '0 && second_of_minute_o == '0))
    else $error("invalid result carries data");

endmodule
